[hdl/heightmap_normal_generator_defines.svh]
// assertion macros for the heightmap normal generator
`ifndef HEIGHTMAP_NORMAL_GENERATOR_DEFINES_SVH
`define HEIGHTMAP_NORMAL_GENERATOR_DEFINES_SVH
`ifndef SYNTHESIS
`define HNG_ASSERT(name, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define HNG_ASSERT_ALWAYS(name, prop, msg) \
    name: assert property (@(posedge clk) prop) else $error(msg);
`else
`define HNG_ASSERT(name, prop, msg)
`define HNG_ASSERT_ALWAYS(name, prop, msg)
`endif
`endif

[hdl/hng_pkg.sv]
package hng_pkg;

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 15;
    localparam int OUT_W      = 16;
    localparam int COL_W      = 10;
    localparam int ROW_W      = 14;
    localparam int GH_W       = 15;
    localparam int QB         = 15;

    localparam logic [CFG_IDX_W-1:0] CFG_GRID_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_HEIGHT = 1'b1;

    localparam logic KIND_SAMPLE = 1'b0;
    localparam logic KIND_DRAIN  = 1'b1;

    localparam int Q14_ONE         = 16384;
    localparam int UP_UNIT         = 256;
    localparam int MAX_GRID_HEIGHT = 16384;
    localparam int GW_CFG_BITS     = 11;

endpackage

[hdl/heightmap_normal_generator.sv]
// Heightmap vertex normal generator: takes heights in raster order (kind 0) and, once a vertex's
// face sums are complete, returns its normalised normal in Q1.14, with drain words (kind 1)
// flushing the last row one vertex per word; a word of the other kind is ignored. Each normal
// is produced by the shared normaliser, which squares and sums the three face-sum components
// (SW = HEIGHT_BITS + 4 bits each), takes a bit-serial square root and divides each component
// by the root with bit-serial long division. The last column of a row emits two normals. A
// stalled output word holds back the loading of the next normal, but a pending output word does
// not block the next input.
module heightmap_normal_generator #(
    parameter int MAX_GRID_WIDTH = 1024,
    parameter int HEIGHT_BITS    = 16
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic                               kind,
    input  logic signed [HEIGHT_BITS-1:0]      height,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic [hng_pkg::OUT_W-1:0]          normal_x,
    output logic [hng_pkg::OUT_W-1:0]          normal_y,
    output logic [hng_pkg::OUT_W-1:0]          normal_z,
    output logic [hng_pkg::COL_W-1:0]          vertex_col,
    output logic [hng_pkg::ROW_W-1:0]          vertex_row,
    output logic                               last_of_run,
    output logic                               grid_done,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [hng_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [hng_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import hng_pkg::*;

    localparam int AW = $clog2(MAX_GRID_WIDTH);
    localparam int WW = $clog2(MAX_GRID_WIDTH + 1);
    localparam int HB = HEIGHT_BITS;
    localparam int SW = HEIGHT_BITS + 4;
    localparam int GW_RESET = (MAX_GRID_WIDTH < 1024) ? MAX_GRID_WIDTH : 1024;

    typedef struct packed {
        logic signed [SW-1:0] x;
        logic signed [SW-1:0] y;
        logic signed [SW-1:0] z;
    } vsum_t;

    typedef enum logic [6:0] {
        T_IDLE   = 7'b0000001,
        T_READ   = 7'b0000010,
        T_CALC   = 7'b0000100,
        T_WR2    = 7'b0001000,
        T_NSTART = 7'b0010000,
        T_NWAIT  = 7'b0100000,
        T_OWAIT  = 7'b1000000
    } tstate_t;

    function automatic vsum_t vadd(vsum_t a, vsum_t b);
        vsum_t s;
        s.x = a.x + b.x;
        s.y = a.y + b.y;
        s.z = a.z + b.z;
        return s;
    endfunction

    logic signed [HB-1:0] hl_mem [MAX_GRID_WIDTH];
    vsum_t                sums_mem [MAX_GRID_WIDTH];
    logic signed [HB-1:0] hl_q;
    vsum_t                sums_q;

    tstate_t              state_reg, state_next;
    logic                 kind_reg, kind_next;
    logic signed [HB-1:0] h_reg, h_next;
    logic [AW-1:0]        c_reg, c_next;
    logic [AW-1:0]        col_reg, col_next;
    logic [ROW_W-1:0]     row_reg, row_next;
    logic [WW-1:0]        drain_reg, drain_next;
    logic                 draining_reg, draining_next;
    logic [WW-1:0]        gw_reg, gw_next;
    logic [GH_W-1:0]      gh_reg, gh_next;
    logic signed [HB-1:0] left_reg, left_next;
    logic signed [HB-1:0] upleft_reg, upleft_next;
    vsum_t                prevacc_reg, prevacc_next;
    vsum_t                curd_reg, curd_next;
    vsum_t                v0_reg, v0_next;
    vsum_t                v1_reg, v1_next;
    logic                 sel_reg, sel_next;
    logic                 two_reg, two_next;
    logic [AW-1:0]        vcol_reg, vcol_next;
    logic [ROW_W-1:0]     vrow_reg, vrow_next;
    logic                 vdone_reg, vdone_next;
    logic                 out_valid_reg, out_valid_next;
    logic [OUT_W-1:0]     nx_reg, nx_next, ny_reg, ny_next, nz_reg, nz_next;
    logic [COL_W-1:0]     ocol_reg, ocol_next;
    logic [ROW_W-1:0]     orow_reg, orow_next;
    logic                 olast_reg, olast_next;
    logic                 odone_reg, odone_next;

    logic                 in_acc;
    logic                 hl_we;
    logic                 sums_we;
    logic [AW-1:0]        sums_waddr;
    vsum_t                sums_wdata;
    logic                 norm_start;
    logic                 norm_done;
    vsum_t                norm_in;
    logic [OUT_W-1:0]     res_x, res_y, res_z;
    logic [WW-1:0]        d_clamp;
    logic [31:0]          cfg_w;
    logic [31:0]          cfg_h;
    logic                 clear;
    vsum_t                base;
    vsum_t                n1v, n2v, nsum;
    logic signed [SW-1:0] ha, hb, hc, hd;
    logic                 lastcol;
    logic                 out_free;

    assign in_stall  = (state_reg != T_IDLE);
    assign in_acc    = in_valid && !in_stall;
    assign cfg_ready = 1'b1;
    assign out_free  = !out_valid_reg || !out_stall;
    assign d_clamp   = (drain_reg >= gw_reg) ? (gw_reg - WW'(1)) : drain_reg;
    assign cfg_w     = 32'(cfg_data[GW_CFG_BITS-1:0]);
    assign cfg_h     = 32'(cfg_data);

    always_comb
    begin
        ha      = SW'(upleft_reg);
        hb      = SW'(hl_q);
        hc      = SW'(left_reg);
        hd      = SW'(h_reg);
        n1v.x   = ha - hb;
        n1v.y   = SW'(UP_UNIT);
        n1v.z   = ha - hc;
        n2v.x   = hc - hd;
        n2v.y   = SW'(UP_UNIT);
        n2v.z   = hb - hd;
        nsum    = vadd(n1v, n2v);
        base    = (row_reg == ROW_W'(1)) ? '0 : sums_q;
        lastcol = ((WW'(c_reg) + WW'(1)) == gw_reg);
        norm_in = sel_reg ? v1_reg : v0_reg;
    end

    always_comb
    begin
        state_next     = state_reg;
        kind_next      = kind_reg;
        h_next         = h_reg;
        c_next         = c_reg;
        col_next       = col_reg;
        row_next       = row_reg;
        drain_next     = drain_reg;
        draining_next  = draining_reg;
        gw_next        = gw_reg;
        gh_next        = gh_reg;
        left_next      = left_reg;
        upleft_next    = upleft_reg;
        prevacc_next   = prevacc_reg;
        curd_next      = curd_reg;
        v0_next        = v0_reg;
        v1_next        = v1_reg;
        sel_next       = sel_reg;
        two_next       = two_reg;
        vcol_next      = vcol_reg;
        vrow_next      = vrow_reg;
        vdone_next     = vdone_reg;
        out_valid_next = out_valid_reg && out_stall;
        nx_next        = nx_reg;
        ny_next        = ny_reg;
        nz_next        = nz_reg;
        ocol_next      = ocol_reg;
        orow_next      = orow_reg;
        olast_next     = olast_reg;
        odone_next     = odone_reg;
        hl_we          = 1'b0;
        sums_we        = 1'b0;
        sums_waddr     = c_reg;
        sums_wdata     = curd_reg;
        norm_start     = 1'b0;
        clear          = 1'b0;

        case (state_reg)
            T_IDLE:
            begin
                if (in_acc)
                begin
                    kind_next = kind;
                    h_next    = height;
                    if (kind == KIND_DRAIN)
                    begin
                        c_next = AW'(d_clamp);
                        if (draining_reg)
                        begin
                            state_next = T_READ;
                        end
                    end
                    else
                    begin
                        c_next = (WW'(col_reg) >= gw_reg) ? '0 : col_reg;
                        if (!draining_reg)
                        begin
                            state_next = T_READ;
                        end
                    end
                end
            end
            T_READ:
            begin
                state_next = T_CALC;
            end
            T_CALC:
            begin
                sel_next = 1'b0;
                if (kind_reg == KIND_DRAIN)
                begin
                    v0_next    = sums_q;
                    two_next   = 1'b0;
                    vcol_next  = c_reg;
                    vrow_next  = ROW_W'(gh_reg - GH_W'(1));
                    vdone_next = (WW'(c_reg) == (gw_reg - WW'(1)));
                    if (vdone_next)
                    begin
                        clear = 1'b1;
                    end
                    else
                    begin
                        drain_next = WW'(c_reg) + WW'(1);
                    end
                    state_next = T_NSTART;
                end
                else
                begin
                    hl_we       = 1'b1;
                    upleft_next = hl_q;
                    left_next   = h_reg;
                    if (row_reg != '0)
                    begin
                        if (c_reg == '0)
                        begin
                            prevacc_next = base;
                            curd_next    = '0;
                        end
                        else
                        begin
                            v0_next      = vadd(prevacc_reg, n1v);
                            prevacc_next = vadd(base, nsum);
                            v1_next      = prevacc_next;
                            curd_next    = n2v;
                            sums_we      = 1'b1;
                            sums_waddr   = c_reg - AW'(1);
                            sums_wdata   = vadd(curd_reg, nsum);
                            two_next     = lastcol;
                            vcol_next    = c_reg - AW'(1);
                            vrow_next    = row_reg - ROW_W'(1);
                            vdone_next   = 1'b0;
                        end
                    end
                    if (lastcol)
                    begin
                        col_next = '0;
                        row_next = row_reg + ROW_W'(1);
                        if ((GH_W'(row_reg) + GH_W'(1)) >= gh_reg)
                        begin
                            draining_next = 1'b1;
                            drain_next    = '0;
                        end
                    end
                    else
                    begin
                        col_next = c_reg + AW'(1);
                    end
                    if (row_reg != '0 && c_reg != '0)
                    begin
                        state_next = lastcol ? T_WR2 : T_NSTART;
                    end
                    else
                    begin
                        state_next = T_IDLE;
                    end
                end
            end
            T_WR2:
            begin
                sums_we    = 1'b1;
                sums_waddr = c_reg;
                sums_wdata = curd_reg;
                state_next = T_NSTART;
            end
            T_NSTART:
            begin
                norm_start = 1'b1;
                state_next = T_NWAIT;
            end
            T_NWAIT:
            begin
                if (norm_done)
                begin
                    state_next = T_OWAIT;
                end
            end
            T_OWAIT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    nx_next        = res_x;
                    ny_next        = res_y;
                    nz_next        = res_z;
                    ocol_next      = sel_reg ? COL_W'(vcol_reg + AW'(1)) : COL_W'(vcol_reg);
                    orow_next      = vrow_reg;
                    odone_next     = vdone_reg;
                    if (!sel_reg && two_reg)
                    begin
                        olast_next = 1'b0;
                        sel_next   = 1'b1;
                        state_next = T_NSTART;
                    end
                    else
                    begin
                        olast_next = 1'b1;
                        state_next = T_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = T_IDLE;
            end
        endcase

        if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_GRID_WIDTH:
                begin
                    if (cfg_w < 32'd2)
                        gw_next = WW'(2);
                    else if (cfg_w > 32'(MAX_GRID_WIDTH))
                        gw_next = WW'(MAX_GRID_WIDTH);
                    else
                        gw_next = WW'(cfg_w);
                    clear = 1'b1;
                end
                CFG_GRID_HEIGHT:
                begin
                    if (cfg_h < 32'd2)
                        gh_next = GH_W'(2);
                    else if (cfg_h > 32'(MAX_GRID_HEIGHT))
                        gh_next = GH_W'(MAX_GRID_HEIGHT);
                    else
                        gh_next = GH_W'(cfg_h);
                    clear = 1'b1;
                end
                default:
                begin
                    clear = 1'b0;
                end
            endcase
        end

        if (clear)
        begin
            col_next      = '0;
            row_next      = '0;
            drain_next    = '0;
            draining_next = 1'b0;
            left_next     = '0;
            upleft_next   = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= T_IDLE;
            col_reg       <= '0;
            row_reg       <= '0;
            drain_reg     <= '0;
            draining_reg  <= 1'b0;
            gw_reg        <= WW'(GW_RESET);
            gh_reg        <= GH_W'(1024);
            left_reg      <= '0;
            upleft_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            col_reg       <= col_next;
            row_reg       <= row_next;
            drain_reg     <= drain_next;
            draining_reg  <= draining_next;
            gw_reg        <= gw_next;
            gh_reg        <= gh_next;
            left_reg      <= left_next;
            upleft_reg    <= upleft_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg    <= kind_next;
        h_reg       <= h_next;
        c_reg       <= c_next;
        prevacc_reg <= prevacc_next;
        curd_reg    <= curd_next;
        v0_reg      <= v0_next;
        v1_reg      <= v1_next;
        sel_reg     <= sel_next;
        two_reg     <= two_next;
        vcol_reg    <= vcol_next;
        vrow_reg    <= vrow_next;
        vdone_reg   <= vdone_next;
        nx_reg      <= nx_next;
        ny_reg      <= ny_next;
        nz_reg      <= nz_next;
        ocol_reg    <= ocol_next;
        orow_reg    <= orow_next;
        olast_reg   <= olast_next;
        odone_reg   <= odone_next;
    end

    // line buffers
    always_ff @(posedge clk)
    begin
        if (hl_we)
        begin
            hl_mem[c_reg] <= h_reg;
        end
        if (sums_we)
        begin
            sums_mem[sums_waddr] <= sums_wdata;
        end
        if (state_reg == T_READ)
        begin
            hl_q   <= hl_mem[c_reg];
            sums_q <= sums_mem[c_reg];
        end
    end

    hng_norm #(
        .SW (SW)
    ) u_norm (
        .clk   (clk),
        .rst_n (rst_n),
        .start (norm_start),
        .in_x  (norm_in.x),
        .in_y  (norm_in.y),
        .in_z  (norm_in.z),
        .done  (norm_done),
        .res_x (res_x),
        .res_y (res_y),
        .res_z (res_z)
    );

    assign out_valid   = out_valid_reg;
    assign normal_x    = nx_reg;
    assign normal_y    = ny_reg;
    assign normal_z    = nz_reg;
    assign vertex_col  = ocol_reg;
    assign vertex_row  = orow_reg;
    assign last_of_run = olast_reg;
    assign grid_done   = odone_reg;

endmodule

[hdl/hng_norm.sv]
module hng_norm #(
    parameter int SW = 20
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic signed [SW-1:0]         in_x,
    input  logic signed [SW-1:0]         in_y,
    input  logic signed [SW-1:0]         in_z,
    output logic                         done,
    output logic [hng_pkg::OUT_W-1:0]    res_x,
    output logic [hng_pkg::OUT_W-1:0]    res_y,
    output logic [hng_pkg::OUT_W-1:0]    res_z
);
    import hng_pkg::*;

    `include "heightmap_normal_generator_defines.svh"

    localparam int SQW = 2*SW + 2;
    localparam int LW  = SW + 1;
    localparam int DW  = SW + 2;
    localparam int NW  = SW + QB + 1;

    typedef enum logic [4:0] {
        N_IDLE = 5'b00001,
        N_SQ   = 5'b00010,
        N_ROOT = 5'b00100,
        N_DIV  = 5'b01000,
        N_DONE = 5'b10000
    } nstate_t;

    nstate_t           state_reg, state_next;
    logic [SW-1:0]     mag_reg [3];
    logic [SW-1:0]     mag_next [3];
    logic [2:0]        neg_reg, neg_next;
    logic [1:0]        idx_reg, idx_next;
    logic [3:0]        step_reg, step_next;
    logic [SQW-1:0]    acc_reg, acc_next;
    logic [SQW-1:0]    root_reg, root_next;
    logic [SQW-1:0]    bit_reg, bit_next;
    logic [DW-1:0]     drem_reg, drem_next;
    logic [QB-1:0]     nlow_reg, nlow_next;
    logic [QB-1:0]     q_reg, q_next;
    logic [OUT_W-1:0]  res_reg [3];
    logic [OUT_W-1:0]  res_next [3];

    logic [SW-1:0]     cur_mag;
    logic [2*SW-1:0]   sq_prod;
    logic [SQW-1:0]    trial;
    logic [LW-1:0]     len;
    logic [NW-1:0]     num;
    logic [DW:0]       dtrial;
    logic [DW:0]       dvs;
    logic              qbit;
    logic [QB-1:0]     q_new;
    logic [QB-1:0]     q_sat;
    logic [OUT_W-1:0]  q_signed;

    always_comb
    begin
        cur_mag  = mag_reg[idx_reg];
        sq_prod  = cur_mag * cur_mag;
        trial    = root_reg + bit_reg;
        len      = root_reg[LW-1:0];
        num      = (NW'(cur_mag) << QB) + NW'(len);
        dtrial   = {drem_reg, nlow_reg[QB-1]};
        dvs      = (DW+1)'({len, 1'b0});
        qbit     = (dtrial >= dvs);
        q_new    = {q_reg[QB-2:0], qbit};
        q_sat    = (q_new > QB'(Q14_ONE)) ? QB'(Q14_ONE) : q_new;
        q_signed = neg_reg[idx_reg] ? OUT_W'(-{1'b0, q_sat}) : OUT_W'({1'b0, q_sat});
    end

    always_comb
    begin
        state_next = state_reg;
        mag_next   = mag_reg;
        neg_next   = neg_reg;
        idx_next   = idx_reg;
        step_next  = step_reg;
        acc_next   = acc_reg;
        root_next  = root_reg;
        bit_next   = bit_reg;
        drem_next  = drem_reg;
        nlow_next  = nlow_reg;
        q_next     = q_reg;
        res_next   = res_reg;
        case (state_reg)
            N_IDLE:
            begin
                if (start)
                begin
                    mag_next[0] = in_x[SW-1] ? SW'(-in_x) : SW'(in_x);
                    mag_next[1] = in_y[SW-1] ? SW'(-in_y) : SW'(in_y);
                    mag_next[2] = in_z[SW-1] ? SW'(-in_z) : SW'(in_z);
                    neg_next    = {in_z[SW-1], in_y[SW-1], in_x[SW-1]};
                    acc_next    = '0;
                    idx_next    = 2'd0;
                    state_next  = N_SQ;
                end
            end
            N_SQ:
            begin
                acc_next = acc_reg + SQW'(sq_prod);
                if (idx_reg == 2'd2)
                begin
                    idx_next  = 2'd0;
                    root_next = '0;
                    bit_next  = SQW'(1) << (SQW-2);
                    if (acc_next == '0)
                    begin
                        res_next[0] = '0;
                        res_next[1] = '0;
                        res_next[2] = '0;
                        state_next  = N_DONE;
                    end
                    else
                    begin
                        state_next = N_ROOT;
                    end
                end
                else
                begin
                    idx_next = idx_reg + 2'd1;
                end
            end
            N_ROOT:
            begin
                if (acc_reg >= trial)
                begin
                    acc_next  = acc_reg - trial;
                    root_next = (root_reg >> 1) + bit_reg;
                end
                else
                begin
                    root_next = root_reg >> 1;
                end
                bit_next = bit_reg >> 2;
                if (bit_reg[0])
                begin
                    idx_next   = 2'd0;
                    step_next  = '0;
                    state_next = N_DIV;
                end
            end
            N_DIV:
            begin
                if (step_reg == '0)
                begin
                    drem_next = DW'(num[NW-1:QB]);
                    nlow_next = num[QB-1:0];
                    q_next    = '0;
                    step_next = 4'd1;
                end
                else
                begin
                    drem_next = qbit ? DW'(dtrial - dvs) : DW'(dtrial);
                    nlow_next = {nlow_reg[QB-2:0], 1'b0};
                    q_next    = q_new;
                    if (step_reg == 4'(QB))
                    begin
                        res_next[idx_reg] = q_signed;
                        step_next         = '0;
                        if (idx_reg == 2'd2)
                        begin
                            state_next = N_DONE;
                        end
                        else
                        begin
                            idx_next = idx_reg + 2'd1;
                        end
                    end
                    else
                    begin
                        step_next = step_reg + 4'd1;
                    end
                end
            end
            N_DONE:
            begin
                state_next = N_IDLE;
            end
            default:
            begin
                state_next = N_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= N_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mag_reg  <= mag_next;
        neg_reg  <= neg_next;
        idx_reg  <= idx_next;
        step_reg <= step_next;
        acc_reg  <= acc_next;
        root_reg <= root_next;
        bit_reg  <= bit_next;
        drem_reg <= drem_next;
        nlow_reg <= nlow_next;
        q_reg    <= q_next;
        res_reg  <= res_next;
    end

    assign done  = (state_reg == N_DONE);
    assign res_x = res_reg[0];
    assign res_y = res_reg[1];
    assign res_z = res_reg[2];

    `HNG_ASSERT(a_start_when_idle, start |-> state_reg == N_IDLE, "normaliser started while busy")
    `HNG_ASSERT_ALWAYS(a_done_single, done |=> !done, "normaliser done held for two cycles")
    `HNG_ASSERT(a_root_fits, state_reg == N_DIV |-> (root_reg >> LW) == '0, "root wider than expected")
    `HNG_ASSERT(a_res_range, done |-> ($signed(res_x) <= Q14_ONE && $signed(res_x) >= -Q14_ONE && $signed(res_z) <= Q14_ONE && $signed(res_z) >= -Q14_ONE), "normal component out of range")

endmodule

[tb/heightmap_normal_generator_tb.sv]
module heightmap_normal_generator_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import hng_pkg::*;

    localparam int GRID_MAX = 1024;
    localparam int SETTLE_CYCLES = 400;
    localparam longint CYCLE_LIMIT = 4000000;

    typedef struct packed {
        logic [OUT_W-1:0] nx;
        logic [OUT_W-1:0] ny;
        logic [OUT_W-1:0] nz;
        logic [COL_W-1:0] col;
        logic [ROW_W-1:0] row;
        logic             last;
        logic             done;
    } normal_t;

    typedef struct {
        logic               k;
        logic signed [15:0] h;
        bit                 flat;
    } stim_row_t;

    logic                    clk = 1'b0;
    logic                    rst_n = 1'b0;
    logic                    in_valid = 1'b0;
    logic                    in_stall;
    logic                    kind = KIND_SAMPLE;
    logic signed [15:0]      height = '0;
    logic                    out_valid;
    logic                    out_stall = 1'b0;
    logic [OUT_W-1:0]        normal_x, normal_y, normal_z;
    logic [COL_W-1:0]        vertex_col;
    logic [ROW_W-1:0]        vertex_row;
    logic                    last_of_run, grid_done;
    logic                    cfg_valid = 1'b0;
    logic                    cfg_ready;
    logic [CFG_IDX_W-1:0]    cfg_index = CFG_GRID_WIDTH;
    logic [CFG_DATA_W-1:0]   cfg_data = '0;

    heightmap_normal_generator dut (.*);

    always #4 clk = ~clk;

    // predictor state
    longint  up_height [GRID_MAX];
    longint  psx [GRID_MAX], psy [GRID_MAX], psz [GRID_MAX];
    longint  csx [GRID_MAX], csy [GRID_MAX], csz [GRID_MAX];
    longint  left_h, up_left_h;
    int      col_pos, row_pos, drain_pos;
    bit      draining;
    int      gw = 1024, gh = 1024;

    normal_t pending_normals [$];
    int      errors = 0;
    longint  cycles = 0;
    int      send_idle_pct = 0, recv_idle_pct = 0;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    always @(posedge clk)
        out_stall <= ($urandom_range(99) < recv_idle_pct);

    task automatic report(string what, longint got, longint want);
        $display("mismatch %s: got %0d expected %0d", what, got, want);
        errors++;
    endtask

    always @(posedge clk)
    begin
        normal_t w;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_normals.size() == 0)
                report("unexpected word", vertex_col, -1);
            else
            begin
                w = pending_normals.pop_front();
                if (normal_x !== w.nx) report("normal_x", normal_x, w.nx);
                if (normal_y !== w.ny) report("normal_y", normal_y, w.ny);
                if (normal_z !== w.nz) report("normal_z", normal_z, w.nz);
                if (vertex_col !== w.col) report("vertex_col", vertex_col, w.col);
                if (vertex_row !== w.row) report("vertex_row", vertex_row, w.row);
                if (last_of_run !== w.last) report("last_of_run", last_of_run, w.last);
                if (grid_done !== w.done) report("grid_done", grid_done, w.done);
            end
        end
    end

    function automatic longint unsigned int_sqrt(longint unsigned s);
        longint unsigned r = 0;
        longint unsigned b = 64'd1 << 62;
        while (b > s) b >>= 2;
        while (b != 0)
        begin
            if (s >= r + b)
            begin
                s -= r + b;
                r = (r >> 1) + b;
            end
            else
                r >>= 1;
            b >>= 2;
        end
        return r;
    endfunction

    function automatic logic [15:0] unit_component(longint c, longint unsigned len);
        longint unsigned m = (c < 0) ? -c : c;
        longint unsigned q = (m * 2 * Q14_ONE + len) / (2 * len);
        if (q > Q14_ONE) q = Q14_ONE;
        if (c < 0) q = -q;
        return q[15:0];
    endfunction

    function automatic normal_t make_normal(longint x, longint y, longint z, int c, int r,
                                            bit last, bit done, bit flat);
        normal_t n;
        longint unsigned sq = x * x + y * y + z * z;
        longint unsigned len;
        if (sq == 0)
        begin
            n.nx = '0; n.ny = '0; n.nz = '0;
        end
        else
        begin
            len = int_sqrt(sq);
            n.nx = unit_component(x, len);
            n.ny = unit_component(y, len);
            n.nz = unit_component(z, len);
        end
        if (flat)
        begin
            n.nx = '0; n.ny = 16'd16384; n.nz = '0;
        end
        n.col = c[COL_W-1:0];
        n.row = r[ROW_W-1:0];
        n.last = last;
        n.done = done;
        return n;
    endfunction

    function automatic void clear_grid();
        for (int i = 0; i < GRID_MAX; i++)
        begin
            psx[i] = 0; psy[i] = 0; psz[i] = 0;
            csx[i] = 0; csy[i] = 0; csz[i] = 0;
        end
        left_h = 0; up_left_h = 0;
        col_pos = 0; row_pos = 0; drain_pos = 0;
        draining = 0;
    endfunction

    function automatic void predict_normals(logic k, logic signed [15:0] h_in, bit flat);
        int d, c, r;
        bit done;
        longint ha, hb, hc, hd, n1x, n1z, n2x, n2z;
        if (k == KIND_DRAIN)
        begin
            if (!draining) return;
            d = (drain_pos >= gw) ? gw - 1 : drain_pos;
            done = (d == gw - 1);
            pending_normals.push_back(make_normal(psx[d], psy[d], psz[d], d, gh - 1, 1,
                                                  done, flat));
            drain_pos = d + 1;
            if (done) clear_grid();
            return;
        end
        if (draining) return;
        c = (col_pos >= gw) ? 0 : col_pos;
        r = row_pos;
        hd = h_in;
        if (r > 0 && c > 0)
        begin
            ha = up_left_h; hb = up_height[c]; hc = left_h;
            n1x = ha - hb; n1z = ha - hc; n2x = hc - hd; n2z = hb - hd;
            psx[c-1] += n1x;       psy[c-1] += UP_UNIT;     psz[c-1] += n1z;
            psx[c] += n1x + n2x;   psy[c] += 2 * UP_UNIT;   psz[c] += n1z + n2z;
            csx[c-1] += n1x + n2x; csy[c-1] += 2 * UP_UNIT; csz[c-1] += n1z + n2z;
            csx[c] += n2x;         csy[c] += UP_UNIT;       csz[c] += n2z;
            pending_normals.push_back(make_normal(psx[c-1], psy[c-1], psz[c-1], c - 1, r - 1,
                                                  c != gw - 1, 0, flat));
            if (c == gw - 1)
                pending_normals.push_back(make_normal(psx[c], psy[c], psz[c], c, r - 1, 1, 0,
                                                      flat));
        end
        up_left_h = up_height[c];
        up_height[c] = hd;
        left_h = hd;
        c++;
        if (c >= gw)
        begin
            c = 0;
            for (int i = 0; i < GRID_MAX; i++)
            begin
                psx[i] = csx[i]; psy[i] = csy[i]; psz[i] = csz[i];
                csx[i] = 0; csy[i] = 0; csz[i] = 0;
            end
            r++;
            if (r >= gh)
            begin
                draining = 1;
                drain_pos = 0;
            end
        end
        col_pos = c;
        row_pos = r;
    endfunction

    task automatic send_word(logic k, logic signed [15:0] h, bit flat = 0);
        if ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
        end
        in_valid <= 1'b1;
        kind <= k;
        height <= h;
        do @(posedge clk); while (in_stall);
        predict_normals(k, h, flat);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int value);
        int v;
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_normals.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value[CFG_DATA_W-1:0];
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == CFG_GRID_WIDTH)
        begin
            v = value & 16'h7ff;
            gw = (v < 2) ? 2 : (v > GRID_MAX) ? GRID_MAX : v;
        end
        else
        begin
            v = value & 16'h7fff;
            gh = (v < 2) ? 2 : (v > MAX_GRID_HEIGHT) ? MAX_GRID_HEIGHT : v;
        end
        clear_grid();
    endtask

    function automatic logic signed [15:0] pick_height();
        int sel = $urandom_range(99);
        if (sel < 55) return 16'($urandom_range(65535));
        if (sel < 90) return 16'($urandom_range(511) - 256);
        return ($urandom_range(1) != 0) ? 16'sh7fff : 16'sh8000;
    endfunction

    // whole grid in raster order, then the drain; a little noise and the odd abort
    task automatic run_grid(int w, int h, bit abort_it);
        int stop_at = abort_it ? $urandom_range(w * h - 1) : w * h;
        write_reg(CFG_GRID_WIDTH, w);
        write_reg(CFG_GRID_HEIGHT, h);
        for (int i = 0; i < stop_at; i++)
        begin
            if ($urandom_range(99) < 3) send_word(KIND_DRAIN, pick_height());
            send_word(KIND_SAMPLE, pick_height());
        end
        if (abort_it) return;
        for (int i = 0; i < gw; i++)
        begin
            if ($urandom_range(99) < 3) send_word(KIND_SAMPLE, pick_height());
            send_word(KIND_DRAIN, pick_height());
        end
    endtask

    stim_row_t directed [] = '{
        '{KIND_DRAIN, 16'sh0000, 0},
        '{KIND_SAMPLE, 16'sh0000, 1}, '{KIND_SAMPLE, 16'sh0000, 1},
        '{KIND_SAMPLE, 16'sh0000, 1}, '{KIND_SAMPLE, 16'sh0000, 1},
        '{KIND_SAMPLE, 16'sh1234, 0},
        '{KIND_DRAIN, 16'sh0000, 1}, '{KIND_DRAIN, 16'shffff, 1},
        '{KIND_SAMPLE, 16'sh7fff, 0}, '{KIND_SAMPLE, 16'sh8000, 0},
        '{KIND_SAMPLE, 16'sh8000, 0}, '{KIND_SAMPLE, 16'sh7fff, 0},
        '{KIND_DRAIN, 16'sh0000, 0}, '{KIND_DRAIN, 16'sh0000, 0},
        '{KIND_SAMPLE, 16'sh7fff, 1}, '{KIND_SAMPLE, 16'sh7fff, 1},
        '{KIND_SAMPLE, 16'sh7fff, 1}, '{KIND_SAMPLE, 16'sh7fff, 1},
        '{KIND_DRAIN, 16'sh7fff, 1}, '{KIND_DRAIN, 16'sh7fff, 1}
    };

    initial
    begin
        int idle_plan [3][2] = '{'{36, 51}, '{51, 36}, '{0, 0}};
        for (int i = 0; i < GRID_MAX; i++) up_height[i] = 0;
        clear_grid();
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        write_reg(CFG_GRID_WIDTH, 0);
        write_reg(CFG_GRID_HEIGHT, 1);
        foreach (directed[i])
            send_word(directed[i].k, directed[i].h, directed[i].flat);

        for (int p = 0; p < 3; p++)
        begin
            send_idle_pct = idle_plan[p][0];
            recv_idle_pct = idle_plan[p][1];
            for (int g = 0; g < 12; g++)
                run_grid($urandom_range(2, 10), $urandom_range(2, 6), $urandom_range(9) == 0);
            if (p == 0)
            begin
                // largest sizes, aborted early by the next write
                write_reg(CFG_GRID_WIDTH, 2047);
                write_reg(CFG_GRID_HEIGHT, 32767);
                for (int i = 0; i < 40; i++) send_word(KIND_SAMPLE, pick_height());
            end
            if (p == 2) run_grid(200, 2, 0);
        end

        in_valid <= 1'b0;
        while (pending_normals.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end
endmodule
